FILE: design/iacm_pkg.sv
// iacm_pkg: shared types and constants for the interface atom contact marker.
// Used by iacm_front, iacm_dist, iacm_back and the top level; no dependencies.
`default_nettype none

package iacm_pkg;

  localparam int SLOT_W    = 6;
  localparam int MAX_ATOMS = 1 << SLOT_W;
  localparam int COORD_W   = 25;
  localparam int CHAIN_W   = 8;
  localparam int CUT_W     = 16;
  localparam int LIM_W     = 2 * CUT_W;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MAG_W     = COORD_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int NSTAGE    = 5;

  localparam logic [CUT_W-1:0]  CUTOFF_RESET = CUT_W'(6000);
  localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(MAX_ATOMS - 1);
  localparam logic [SLOT_W-1:0] PEN_SLOT     = SLOT_W'(MAX_ATOMS - 2);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [CHAIN_W-1:0]        chain;
  } atom_t;

  localparam int ATOM_W = $bits(atom_t);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    atom_t             atom;
    logic              last;
  } item_t;

  // pair tag travelling with a distance evaluation
  typedef struct packed {
    logic              vld;
    logic              ok;
    logic [SLOT_W-1:0] i;
    logic [SLOT_W-1:0] j;
  } pair_tag_t;

  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [SLOT_W-1:0] i;
    logic [SLOT_W-1:0] j;
  } pair_res_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PAIR  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

FILE: design/iacm_ram.sv
// iacm_ram: generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none

module iacm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: design/iacm_front.sv
// iacm_front: accepts input beats, tags them and holds them in a short queue.
// Depends on iacm_pkg.
`default_nettype none

module iacm_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [iacm_pkg::SLOT_W-1:0]    in_slot,
  input  wire logic signed [iacm_pkg::COORD_W-1:0] in_x_milli,
  input  wire logic signed [iacm_pkg::COORD_W-1:0] in_y_milli,
  input  wire logic signed [iacm_pkg::COORD_W-1:0] in_z_milli,
  input  wire logic [iacm_pkg::CHAIN_W-1:0]   in_chain_id,
  input  wire logic                           in_last,
  output logic                                q_vld,
  input  wire logic                           q_rdy,
  output iacm_pkg::item_t                     q_item
);

  iacm_pkg::item_t                  mem_r [iacm_pkg::QDEPTH];
  logic [iacm_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [iacm_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [iacm_pkg::QPTR_W:0]        cnt_r, cnt_nxt;
  iacm_pkg::item_t                  in_item;
  logic                             push, pop;

  always_comb begin
    in_item.slot       = in_slot;
    in_item.atom.x     = in_x_milli;
    in_item.atom.y     = in_y_milli;
    in_item.atom.z     = in_z_milli;
    in_item.atom.chain = in_chain_id;
    in_item.last       = in_last;
  end

  assign in_ready = (cnt_r != (iacm_pkg::QPTR_W + 1)'(iacm_pkg::QDEPTH));
  assign q_vld    = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_vld && q_rdy;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: design/iacm_dist.sv
// iacm_dist: pipelined squared-distance test of one atom pair per cycle.
// Depends on iacm_pkg.
`default_nettype none

module iacm_dist (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire iacm_pkg::pair_tag_t          req,
  input  wire iacm_pkg::atom_t              atom_a,
  input  wire iacm_pkg::atom_t              atom_b,
  input  wire logic [iacm_pkg::LIM_W-1:0]   limit,
  output iacm_pkg::pair_res_t               res,
  output logic                              busy
);

  // stage valid bits and tags
  logic [iacm_pkg::NSTAGE-1:0]       vld_r;
  logic                              ok_r [iacm_pkg::NSTAGE];
  logic [iacm_pkg::SLOT_W-1:0]       ti_r [iacm_pkg::NSTAGE];
  logic [iacm_pkg::SLOT_W-1:0]       tj_r [iacm_pkg::NSTAGE];

  logic signed [iacm_pkg::DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic [iacm_pkg::MAG_W-1:0]         mx_r, my_r, mz_r;
  logic [iacm_pkg::SQ_W-1:0]          sqx_r, sqy_r, sqz_r, sqz2_r;
  logic [iacm_pkg::SQ_W:0]            sxy_r;
  logic [iacm_pkg::SUM_W-1:0]         tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[iacm_pkg::NSTAGE-2:0], req.vld};
    end
  end

  always_ff @(posedge clk) begin
    ok_r[0] <= req.ok && (atom_a.chain != atom_b.chain);
    ti_r[0] <= req.i;
    tj_r[0] <= req.j;
    for (int s = 1; s < iacm_pkg::NSTAGE; s++) begin
      ok_r[s] <= ok_r[s-1];
      ti_r[s] <= ti_r[s-1];
      tj_r[s] <= tj_r[s-1];
    end
    // stage 1: differences
    dx_r <= iacm_pkg::DIFF_W'(atom_a.x) - iacm_pkg::DIFF_W'(atom_b.x);
    dy_r <= iacm_pkg::DIFF_W'(atom_a.y) - iacm_pkg::DIFF_W'(atom_b.y);
    dz_r <= iacm_pkg::DIFF_W'(atom_a.z) - iacm_pkg::DIFF_W'(atom_b.z);
    // stage 2: magnitudes fit in COORD_W bits
    mx_r <= dx_r[iacm_pkg::DIFF_W-1] ? iacm_pkg::MAG_W'(-dx_r) : iacm_pkg::MAG_W'(dx_r);
    my_r <= dy_r[iacm_pkg::DIFF_W-1] ? iacm_pkg::MAG_W'(-dy_r) : iacm_pkg::MAG_W'(dy_r);
    mz_r <= dz_r[iacm_pkg::DIFF_W-1] ? iacm_pkg::MAG_W'(-dz_r) : iacm_pkg::MAG_W'(dz_r);
    // stage 3: squares
    sqx_r <= mx_r * mx_r;
    sqy_r <= my_r * my_r;
    sqz_r <= mz_r * mz_r;
    // stage 4: partial sum
    sxy_r  <= {1'b0, sqx_r} + {1'b0, sqy_r};
    sqz2_r <= sqz_r;
    // stage 5: full sum
    tot_r <= {1'b0, sxy_r} + {2'b00, sqz2_r};
  end

  assign res.vld = vld_r[iacm_pkg::NSTAGE-1];
  assign res.hit = ok_r[iacm_pkg::NSTAGE-1] && (tot_r <= iacm_pkg::SUM_W'(limit));
  assign res.i   = ti_r[iacm_pkg::NSTAGE-1];
  assign res.j   = tj_r[iacm_pkg::NSTAGE-1];
  assign busy    = |vld_r;

endmodule

`default_nettype wire

FILE: design/iacm_back.sv
// iacm_back: stores atoms, sweeps all slot pairs through the distance pipe
// and emits per-slot results. Depends on iacm_pkg, iacm_ram, iacm_dist.
`default_nettype none

module iacm_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [iacm_pkg::CUT_W-1:0]    cfg_wdata,
  input  wire logic                          q_vld,
  output logic                               q_rdy,
  input  wire iacm_pkg::item_t               q_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [iacm_pkg::SLOT_W-1:0]        out_slot_out,
  output logic                               out_is_interface,
  output logic                               out_last_out
);

  iacm_pkg::state_t                 state_r, state_nxt;
  logic [iacm_pkg::CUT_W-1:0]       cutoff_r;
  logic [iacm_pkg::LIM_W-1:0]       limit_r;
  logic [iacm_pkg::MAX_ATOMS-1:0]   loaded_r, loaded_nxt;
  logic [iacm_pkg::MAX_ATOMS-1:0]   near_r, near_nxt;
  logic [iacm_pkg::MAX_ATOMS-1:0]   rest;
  logic [iacm_pkg::SLOT_W-1:0]      i_r, i_nxt, j_r, j_nxt, e_r, e_nxt;
  logic                             rd_vld_r, rd_ok_r;
  logic [iacm_pkg::SLOT_W-1:0]      rd_i_r, rd_j_r;
  logic                             out_vld_r, out_vld_nxt;
  logic [iacm_pkg::SLOT_W-1:0]      out_slot_r;
  logic                             out_intf_r, out_last_r;
  logic                             pop, issue, out_load, out_free;
  logic [iacm_pkg::ATOM_W-1:0]      rdata_a, rdata_b;
  iacm_pkg::pair_tag_t              req;
  iacm_pkg::pair_res_t              res;
  logic                             dist_busy;

  assign q_rdy    = (state_r == iacm_pkg::ST_IDLE);
  assign pop      = q_vld && q_rdy;
  assign issue    = (state_r == iacm_pkg::ST_PAIR);
  assign out_free = !out_vld_r || out_ready;

  iacm_ram #(.WIDTH(iacm_pkg::ATOM_W), .DEPTH(iacm_pkg::MAX_ATOMS)) u_ram_a (
    .clk   (clk),
    .we    (pop),
    .waddr (q_item.slot),
    .wdata (q_item.atom),
    .raddr (i_r),
    .rdata (rdata_a)
  );

  iacm_ram #(.WIDTH(iacm_pkg::ATOM_W), .DEPTH(iacm_pkg::MAX_ATOMS)) u_ram_b (
    .clk   (clk),
    .we    (pop),
    .waddr (q_item.slot),
    .wdata (q_item.atom),
    .raddr (j_r),
    .rdata (rdata_b)
  );

  always_comb begin
    req.vld = rd_vld_r;
    req.ok  = rd_ok_r;
    req.i   = rd_i_r;
    req.j   = rd_j_r;
  end

  iacm_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .atom_a (iacm_pkg::atom_t'(rdata_a)),
    .atom_b (iacm_pkg::atom_t'(rdata_b)),
    .limit  (limit_r),
    .res    (res),
    .busy   (dist_busy)
  );

  always_comb begin
    rest       = loaded_r;
    rest[e_r]  = 1'b0;
  end

  always_comb begin
    state_nxt   = state_r;
    loaded_nxt  = loaded_r;
    near_nxt    = near_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    e_nxt       = e_r;
    out_load    = 1'b0;
    out_vld_nxt = out_vld_r && !out_ready;

    if (res.vld && res.hit) begin
      near_nxt[res.i] = 1'b1;
      near_nxt[res.j] = 1'b1;
    end

    case (state_r)
      iacm_pkg::ST_IDLE: begin
        if (pop) begin
          loaded_nxt[q_item.slot] = 1'b1;
          if (q_item.last) begin
            i_nxt     = '0;
            j_nxt     = iacm_pkg::SLOT_W'(1);
            state_nxt = iacm_pkg::ST_PAIR;
          end
        end
      end
      iacm_pkg::ST_PAIR: begin
        if (j_r == iacm_pkg::LAST_SLOT) begin
          if (i_r == iacm_pkg::PEN_SLOT) begin
            state_nxt = iacm_pkg::ST_DRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
            j_nxt = i_r + iacm_pkg::SLOT_W'(2);
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      iacm_pkg::ST_DRAIN: begin
        if (!dist_busy) begin
          e_nxt     = '0;
          state_nxt = iacm_pkg::ST_EMIT;
        end
      end
      iacm_pkg::ST_EMIT: begin
        if (!loaded_r[e_r] || out_free) begin
          if (loaded_r[e_r]) begin
            out_load        = 1'b1;
            out_vld_nxt     = 1'b1;
            loaded_nxt[e_r] = 1'b0;
          end
          if (e_r == iacm_pkg::LAST_SLOT) begin
            loaded_nxt = '0;
            near_nxt   = '0;
            state_nxt  = iacm_pkg::ST_IDLE;
          end else begin
            e_nxt = e_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = iacm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= iacm_pkg::ST_IDLE;
      cutoff_r  <= iacm_pkg::CUTOFF_RESET;
      loaded_r  <= '0;
      near_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) begin
        cutoff_r <= cfg_wdata;
      end
      loaded_r  <= loaded_nxt;
      near_r    <= near_nxt;
      rd_vld_r  <= issue;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= cutoff_r * cutoff_r;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    e_r     <= e_nxt;
    rd_i_r  <= i_r;
    rd_j_r  <= j_r;
    rd_ok_r <= loaded_r[i_r] && loaded_r[j_r];
    if (out_load) begin
      out_slot_r <= e_r;
      out_intf_r <= near_r[e_r];
      out_last_r <= (rest == '0);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_slot_out     = out_slot_r;
  assign out_is_interface = out_intf_r;
  assign out_last_out     = out_last_r;

`ifndef SYNTH
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !$past(out_vld_r)) |-> $past(state_r == iacm_pkg::ST_EMIT))
    else $error("result beat raised outside the emit scan");

  a_near_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != iacm_pkg::ST_EMIT) |-> ((near_r & ~loaded_r) == '0))
    else $error("interface flag set on an unloaded slot");

  a_pipe_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iacm_pkg::ST_IDLE || state_r == iacm_pkg::ST_EMIT) |-> !dist_busy)
    else $error("distance pipe active outside the pair sweep");
`endif

endmodule

`default_nettype wire

FILE: design/interface_atom_contact_marker.sv
// Interface atom contact marker. A plain atom beat is held in the front queue and
// stored when the back end pops it; atoms load at one per cycle while it is idle.
// A last beat starts a sweep over all MAX_ATOMS*(MAX_ATOMS-1)/2 slot pairs (2016
// pairs, one pair per cycle through the distance pipe), a drain of that pipe,
// then a slot scan giving at most one result beat per cycle, held by out_ready.
// Synchronous reset: clears queue, masks and output valid, cutoff back to 6000.
`default_nettype none

module interface_atom_contact_marker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [iacm_pkg::CUT_W-1:0]          cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [iacm_pkg::SLOT_W-1:0]         in_slot,
  input  wire logic signed [iacm_pkg::COORD_W-1:0] in_x_milli,
  input  wire logic signed [iacm_pkg::COORD_W-1:0] in_y_milli,
  input  wire logic signed [iacm_pkg::COORD_W-1:0] in_z_milli,
  input  wire logic [iacm_pkg::CHAIN_W-1:0]        in_chain_id,
  input  wire logic                                in_last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [iacm_pkg::SLOT_W-1:0]              out_slot_out,
  output logic                                     out_is_interface,
  output logic                                     out_last_out
);

  logic            q_vld, q_rdy;
  iacm_pkg::item_t q_item;

  iacm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_slot     (in_slot),
    .in_x_milli  (in_x_milli),
    .in_y_milli  (in_y_milli),
    .in_z_milli  (in_z_milli),
    .in_chain_id (in_chain_id),
    .in_last     (in_last),
    .q_vld       (q_vld),
    .q_rdy       (q_rdy),
    .q_item      (q_item)
  );

  iacm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .q_vld            (q_vld),
    .q_rdy            (q_rdy),
    .q_item           (q_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_out     (out_slot_out),
    .out_is_interface (out_is_interface),
    .out_last_out     (out_last_out)
  );

endmodule

`default_nettype wire

FILE: test/interface_atom_contact_marker_tb.sv
// Testbench for interface_atom_contact_marker: directed atom sets, then random sets.
// Checks every result beat against table flags or an in-bench contact predictor.
// Depends on iacm_pkg and the interface_atom_contact_marker RTL.
`default_nettype none

module interface_atom_contact_marker_tb;

  localparam int RAND_ATOMS  = 200;
  localparam int QUIET_LIMIT = 10000;  // longer than one pair sweep, which has no handshakes
  localparam int CFG_SETTLE  = 72;     // outlasts the slot scan after the last beat
  localparam int TAIL_CYCLES = 100;

  localparam logic [iacm_pkg::CHAIN_W-1:0] CH_A = 8'h41;
  localparam logic [iacm_pkg::CHAIN_W-1:0] CH_B = 8'h42;

  typedef enum logic {ROW_ATOM, ROW_CUT} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    iacm_pkg::item_t                 beat;
    logic [iacm_pkg::CUT_W-1:0]      cut;
    bit                              typed;
    logic [iacm_pkg::MAX_ATOMS-1:0]  near;
  } dir_row_t;

  typedef struct packed {
    logic [iacm_pkg::SLOT_W-1:0] slot;
    logic                        near;
    logic                        fin;
  } mark_t;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [iacm_pkg::CUT_W-1:0]          cfg_wdata;
  logic                                in_valid;
  logic                                in_ready;
  logic [iacm_pkg::SLOT_W-1:0]         in_slot;
  logic signed [iacm_pkg::COORD_W-1:0] in_x_milli;
  logic signed [iacm_pkg::COORD_W-1:0] in_y_milli;
  logic signed [iacm_pkg::COORD_W-1:0] in_z_milli;
  logic [iacm_pkg::CHAIN_W-1:0]        in_chain_id;
  logic                                in_last;
  logic                                out_valid;
  logic                                out_ready;
  logic [iacm_pkg::SLOT_W-1:0]         out_slot_out;
  logic                                out_is_interface;
  logic                                out_last_out;

  interface_atom_contact_marker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_slot          (in_slot),
    .in_x_milli       (in_x_milli),
    .in_y_milli       (in_y_milli),
    .in_z_milli       (in_z_milli),
    .in_chain_id      (in_chain_id),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_out     (out_slot_out),
    .out_is_interface (out_is_interface),
    .out_last_out     (out_last_out)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // predictor state
  logic signed [iacm_pkg::COORD_W-1:0] atom_x [iacm_pkg::MAX_ATOMS];
  logic signed [iacm_pkg::COORD_W-1:0] atom_y [iacm_pkg::MAX_ATOMS];
  logic signed [iacm_pkg::COORD_W-1:0] atom_z [iacm_pkg::MAX_ATOMS];
  logic [iacm_pkg::CHAIN_W-1:0]        atom_chain [iacm_pkg::MAX_ATOMS];
  logic [iacm_pkg::MAX_ATOMS-1:0]      loaded;
  logic [iacm_pkg::CUT_W-1:0]          cut_model;

  mark_t    marks_due[$];
  dir_row_t dir_tab[$];

  bit calm;
  int fails;
  int atoms_sent;
  int sets_done;
  int beats_seen;
  int near_seen;

  function automatic int pause_len();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic dir_row_t atom_row(int slot, int x, int y, int z,
                                        logic [iacm_pkg::CHAIN_W-1:0] chain, bit last,
                                        logic [iacm_pkg::MAX_ATOMS-1:0] near);
    dir_row_t r;
    r.kind            = ROW_ATOM;
    r.beat.slot       = iacm_pkg::SLOT_W'(slot);
    r.beat.atom.x     = iacm_pkg::COORD_W'(x);
    r.beat.atom.y     = iacm_pkg::COORD_W'(y);
    r.beat.atom.z     = iacm_pkg::COORD_W'(z);
    r.beat.atom.chain = chain;
    r.beat.last       = last;
    r.cut             = '0;
    r.typed           = last;
    r.near            = near;
    return r;
  endfunction

  function automatic dir_row_t cut_row(logic [iacm_pkg::CUT_W-1:0] v);
    dir_row_t r;
    r       = atom_row(0, 0, 0, 0, '0, 1'b0, '0);
    r.kind  = ROW_CUT;
    r.cut   = v;
    r.typed = 1'b0;
    return r;
  endfunction

  // mark every loaded atom within the cutoff of a loaded atom on another chain
  function automatic logic [iacm_pkg::MAX_ATOMS-1:0] contact_flags();
    logic [iacm_pkg::MAX_ATOMS-1:0] near;
    longint dx, dy, dz, lim;
    near = '0;
    lim  = longint'(cut_model) * longint'(cut_model);
    for (int i = 0; i < iacm_pkg::MAX_ATOMS; i++) begin
      for (int j = i + 1; j < iacm_pkg::MAX_ATOMS; j++) begin
        if (loaded[i] && loaded[j] && atom_chain[i] != atom_chain[j]) begin
          dx = longint'(atom_x[i]) - longint'(atom_x[j]);
          dy = longint'(atom_y[i]) - longint'(atom_y[j]);
          dz = longint'(atom_z[i]) - longint'(atom_z[j]);
          if (dx * dx + dy * dy + dz * dz <= lim) begin
            near[i] = 1'b1;
            near[j] = 1'b1;
          end
        end
      end
    end
    return near;
  endfunction

  // store an accepted atom; a last beat queues one mark per loaded slot
  function automatic void load_atom(iacm_pkg::item_t b, bit typed,
                                    logic [iacm_pkg::MAX_ATOMS-1:0] near_typed);
    logic [iacm_pkg::MAX_ATOMS-1:0] near;
    int left;
    mark_t m;
    atom_x[b.slot]     = b.atom.x;
    atom_y[b.slot]     = b.atom.y;
    atom_z[b.slot]     = b.atom.z;
    atom_chain[b.slot] = b.atom.chain;
    loaded[b.slot]     = 1'b1;
    atoms_sent++;
    if (!b.last) return;
    near = typed ? near_typed : contact_flags();
    left = $countones(loaded);
    for (int i = 0; i < iacm_pkg::MAX_ATOMS; i++) begin
      if (loaded[i]) begin
        left--;
        m.slot = iacm_pkg::SLOT_W'(i);
        m.near = near[i];
        m.fin  = (left == 0);
        marks_due.push_back(m);
      end
    end
    loaded = '0;
    sets_done++;
  endfunction

  task automatic push_atom(iacm_pkg::item_t b, bit typed,
                           logic [iacm_pkg::MAX_ATOMS-1:0] near_typed);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_slot     <= b.slot;
    in_x_milli  <= b.atom.x;
    in_y_milli  <= b.atom.y;
    in_z_milli  <= b.atom.z;
    in_chain_id <= b.atom.chain;
    in_last     <= b.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    load_atom(b, typed, near_typed);
  endtask

  task automatic drain_marks();
    while (marks_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_cutoff(logic [iacm_pkg::CUT_W-1:0] v);
    in_valid <= 1'b0;
    drain_marks();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cut_model = v;
  endtask

  // result side: random stalls, each beat checked against the oldest mark
  initial begin : result_sink
    int gap;
    mark_t m;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = pause_len();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats_seen++;
      if (out_is_interface) near_seen++;
      if (marks_due.size() == 0) begin
        $error("result beat with nothing expected: slot_out %0d", out_slot_out);
        fails++;
      end else begin
        m = marks_due.pop_front();
        if (out_slot_out !== m.slot) begin
          $error("slot_out: expected %0d, got %0d", m.slot, out_slot_out);
          fails++;
        end
        if (out_is_interface !== m.near) begin
          $error("is_interface: expected %0d, got %0d (slot %0d)",
                 m.near, out_is_interface, m.slot);
          fails++;
        end
        if (out_last_out !== m.fin) begin
          $error("last_out: expected %0d, got %0d (slot %0d)", m.fin, out_last_out, m.slot);
          fails++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end while (quiet < QUIET_LIMIT);
    $display("[interface_atom_contact_marker] ERROR");
    $finish;
  end

  initial begin : stimulus
    iacm_pkg::item_t b;
    int rand_atoms;
    int n;
    int reach;
    int off;
    int start;
    bit big;
    bit clustered;
    logic [iacm_pkg::CHAIN_W-1:0] base_chain;
    logic signed [iacm_pkg::COORD_W-1:0] cx, cy, cz;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_slot     = '0;
    in_x_milli  = '0;
    in_y_milli  = '0;
    in_z_milli  = '0;
    in_chain_id = '0;
    in_last     = 1'b0;
    calm        = 1'b0;
    fails       = 0;
    atoms_sent  = 0;
    sets_done   = 0;
    beats_seen  = 0;
    near_seen   = 0;
    loaded      = '0;
    cut_model   = iacm_pkg::CUTOFF_RESET;

    // lone atom right after reset
    dir_tab.push_back(atom_row(0, 0, 0, 0, CH_A, 1'b1, '0));
    // exactly at the default cutoff: inclusive
    dir_tab.push_back(atom_row(5, 0, 0, 0, CH_A, 1'b0, '0));
    dir_tab.push_back(atom_row(9, 6000, 0, 0, CH_B, 1'b1, (64'd1 << 5) | (64'd1 << 9)));
    // one past the cutoff
    dir_tab.push_back(atom_row(1, 0, 0, 0, CH_A, 1'b0, '0));
    dir_tab.push_back(atom_row(2, 0, -6001, 0, CH_B, 1'b1, '0));
    // diagonal just inside
    dir_tab.push_back(atom_row(10, 0, 0, 0, 8'h01, 1'b0, '0));
    dir_tab.push_back(atom_row(11, 3464, 3464, 3464, 8'h02, 1'b1,
                               (64'd1 << 10) | (64'd1 << 11)));
    // same chain, same spot
    dir_tab.push_back(atom_row(3, 100, 100, 100, CH_A, 1'b0, '0));
    dir_tab.push_back(atom_row(4, 100, 100, 100, CH_A, 1'b1, '0));
    // slot 7 reloaded far away before the last beat
    dir_tab.push_back(atom_row(7, 0, 0, 0, CH_A, 1'b0, '0));
    dir_tab.push_back(atom_row(8, 0, 0, 0, CH_B, 1'b0, '0));
    dir_tab.push_back(atom_row(7, 16777215, 0, 0, CH_A, 1'b1, '0));
    // coordinate and chain extremes
    dir_tab.push_back(atom_row(0, -16777216, 16777215, -1, 8'h00, 1'b0, '0));
    dir_tab.push_back(atom_row(61, 16777215, 16777215, 16777115, 8'h00, 1'b0, '0));
    dir_tab.push_back(atom_row(62, 16777215, 16777215, 16777215, 8'hFF, 1'b0, '0));
    dir_tab.push_back(atom_row(63, 16777215, -16777216, 0, 8'hFF, 1'b1,
                               (64'd1 << 61) | (64'd1 << 62)));
    // zero cutoff: only coincident atoms touch
    dir_tab.push_back(cut_row('0));
    dir_tab.push_back(atom_row(20, -5, 7, 9, 8'h58, 1'b0, '0));
    dir_tab.push_back(atom_row(21, -5, 7, 9, 8'h59, 1'b0, '0));
    dir_tab.push_back(atom_row(22, -5, 7, 10, 8'h5A, 1'b1, (64'd1 << 20) | (64'd1 << 21)));
    // widest cutoff
    dir_tab.push_back(cut_row(16'hFFFF));
    dir_tab.push_back(atom_row(30, 0, 0, 0, CH_A, 1'b0, '0));
    dir_tab.push_back(atom_row(31, 0, 0, 65535, CH_B, 1'b0, '0));
    dir_tab.push_back(atom_row(32, 0, 0, -65536, CH_B, 1'b1, (64'd1 << 30) | (64'd1 << 31)));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CUT) set_cutoff(dir_tab[r].cut);
      else push_atom(dir_tab[r].beat, dir_tab[r].typed, dir_tab[r].near);
    end

    rand_atoms = 0;
    while (rand_atoms < RAND_ATOMS) begin
      if (sets_done % 5 == 4) begin
        case ($urandom_range(0, 4))
          0:       set_cutoff('0);
          1:       set_cutoff(16'hFFFF);
          2:       set_cutoff(iacm_pkg::CUTOFF_RESET);
          default: set_cutoff(iacm_pkg::CUT_W'($urandom_range(1, 20000)));
        endcase
      end else if ($urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        drain_marks();
      end
      calm       = ($urandom_range(0, 3) == 0);
      big        = ($urandom_range(0, 7) == 0);
      n          = big ? $urandom_range(32, 64) : $urandom_range(1, 10);
      clustered  = ($urandom_range(0, 3) != 0);
      base_chain = iacm_pkg::CHAIN_W'($urandom());
      cx         = iacm_pkg::COORD_W'($urandom());
      cy         = iacm_pkg::COORD_W'($urandom());
      cz         = iacm_pkg::COORD_W'($urandom());
      reach      = int'(cut_model) + int'(cut_model) / 4 + 4;
      start      = $urandom_range(0, iacm_pkg::MAX_ATOMS - 1);
      for (int k = 0; k < n; k++) begin
        // big sets sweep consecutive slots; small ones pick freely (reloads happen)
        b.slot = big ? iacm_pkg::SLOT_W'(start + k)
                     : iacm_pkg::SLOT_W'($urandom_range(0, iacm_pkg::MAX_ATOMS - 1));
        if (clustered) begin
          b.atom.chain = base_chain + iacm_pkg::CHAIN_W'($urandom_range(0, 2));
          if ($urandom_range(0, 5) == 0) begin
            b.atom.x = cx;
            b.atom.y = cy;
            b.atom.z = cz;
          end else begin
            off = $urandom_range(0, 2 * reach) - reach;
            b.atom.x = cx + iacm_pkg::COORD_W'(off);
            off = $urandom_range(0, 2 * reach) - reach;
            b.atom.y = cy + iacm_pkg::COORD_W'(off);
            off = $urandom_range(0, 2 * reach) - reach;
            b.atom.z = cz + iacm_pkg::COORD_W'(off);
          end
        end else begin
          b.atom.chain = iacm_pkg::CHAIN_W'($urandom());
          b.atom.x     = iacm_pkg::COORD_W'($urandom());
          b.atom.y     = iacm_pkg::COORD_W'($urandom());
          b.atom.z     = iacm_pkg::COORD_W'($urandom());
        end
        b.last = (k == n - 1);
        push_atom(b, 1'b0, '0);
        rand_atoms++;
      end
    end

    in_valid <= 1'b0;
    drain_marks();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d atom beats in %0d sets, %0d result beats (%0d interface)",
             atoms_sent, sets_done, beats_seen, near_seen);
    $display("cutoffs 0, 65535 and several others; slot reloads, coordinate extremes");
    if (fails == 0) begin
      $display("[interface_atom_contact_marker] OK");
    end else begin
      $display("[interface_atom_contact_marker] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
